FILE: hdl/stack_and_fifo_transfer_engine_top_macros.svh
// Assertion macros for the stack and FIFO transfer engine
`ifndef STACK_AND_FIFO_TRANSFER_ENGINE_TOP_MACROS_SVH
`define STACK_AND_FIFO_TRANSFER_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SFTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SFTE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define SFTE_ASSERT(lbl, prop, msg)
`define SFTE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hdl/sfte_pkg.sv
// Types and codes shared by the stack and FIFO transfer engine
package sfte_pkg;

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_CLR_S   = 4'd2,
    OP_ENQ     = 4'd3,
    OP_DEQ     = 4'd4,
    OP_CLR_Q   = 4'd5,
    OP_S2Q     = 4'd6,
    OP_Q2S     = 4'd7,
    OP_ALL_S2Q = 4'd8,
    OP_ALL_Q2S = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER,
    S_NOTE
  } state_e;

  localparam logic SRC_STACK = 1'b0;
  localparam logic SRC_QUEUE = 1'b1;

  typedef struct packed {
    logic s_we;
    logic s_re;
    logic q_we;
    logic q_re;
  } mem_ctl_t;

endpackage

FILE: hdl/sfte_ram.sv
// Single-port-write, registered-read word memory
module sfte_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/sfte_ctrl.sv
// Sequencer: pointers, counts, memory requests and result formatting
`include "stack_and_fifo_transfer_engine_top_macros.svh"
module sfte_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [3:0]         op_i,
  input  logic [31:0]        value_i,
  output logic               busy_o,
  output sfte_pkg::mem_ctl_t mem_o,
  output logic [AW-1:0]      s_waddr_o,
  output logic [AW-1:0]      s_raddr_o,
  output logic [31:0]        s_wdata_o,
  input  logic [31:0]        s_rdata_i,
  output logic [AW-1:0]      q_waddr_o,
  output logic [AW-1:0]      q_raddr_o,
  output logic [31:0]        q_wdata_o,
  input  logic [31:0]        q_rdata_i,
  output logic               valid_o,
  output logic [31:0]        result_value_o,
  output logic               source_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import sfte_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] sc_q, sc_d, qc_q, qc_d;
  logic [AW-1:0] qh_q, qh_d, qt_q, qt_d;
  logic          src_q, src_d, move_q, move_d, bulk_q, bulk_d;
  status_e       note_st_q, note_st_d;
  logic          note_src_q, note_src_d;

  logic          s_empty, s_full, q_empty, q_full;
  logic [CW-1:0] sc_m1;
  logic [AW-1:0] qh_inc, qt_inc;
  logic          src_left, dst_full_nx, more;

  // accept decode
  logic    dec_xfer, dec_note, dec_src, dec_move, dec_bulk;
  status_e dec_st;
  op_e     op;

  assign op      = op_e'(op_i);
  assign s_empty = (sc_q == '0);
  assign s_full  = (sc_q == CW'(DEPTH));
  assign q_empty = (qc_q == '0);
  assign q_full  = (qc_q == CW'(DEPTH));
  assign sc_m1   = sc_q - CW'(1);
  assign qh_inc  = (qh_q == AW'(DEPTH - 1)) ? '0 : qh_q + AW'(1);
  assign qt_inc  = (qt_q == AW'(DEPTH - 1)) ? '0 : qt_q + AW'(1);

  // counts are already decremented for the word in flight
  assign src_left    = src_q ? !q_empty : !s_empty;
  assign dst_full_nx = move_q && (src_q ? (sc_q == CW'(DEPTH - 1))
                                        : (qc_q == CW'(DEPTH - 1)));
  assign more        = bulk_q && src_left;
  assign busy_o      = (state_q != S_IDLE);

  always_comb begin
    dec_xfer = 1'b0;
    dec_note = 1'b0;
    dec_st   = ST_OK;
    dec_src  = SRC_STACK;
    dec_move = 1'b0;
    dec_bulk = 1'b0;
    unique case (op) inside
      OP_PUSH: begin
        dec_note = s_full;
        dec_st   = ST_FULL;
      end
      OP_ENQ: begin
        dec_note = q_full;
        dec_st   = ST_FULL;
        dec_src  = SRC_QUEUE;
      end
      OP_POP, OP_CLR_S, OP_S2Q, OP_ALL_S2Q: begin
        dec_move = (op == OP_S2Q) || (op == OP_ALL_S2Q);
        dec_bulk = (op == OP_CLR_S) || (op == OP_ALL_S2Q);
        if (s_empty) begin
          dec_note = 1'b1;
          dec_st   = ST_EMPTY;
        end else if (dec_move && q_full) begin
          dec_note = 1'b1;
          dec_st   = ST_FULL;
        end else begin
          dec_xfer = 1'b1;
        end
      end
      OP_DEQ, OP_CLR_Q, OP_Q2S, OP_ALL_Q2S: begin
        dec_src  = SRC_QUEUE;
        dec_move = (op == OP_Q2S) || (op == OP_ALL_Q2S);
        dec_bulk = (op == OP_CLR_Q) || (op == OP_ALL_Q2S);
        if (q_empty) begin
          dec_note = 1'b1;
          dec_st   = ST_EMPTY;
        end else if (dec_move && s_full) begin
          dec_note = 1'b1;
          dec_st   = ST_FULL;
        end else begin
          dec_xfer = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && dec_note) begin
          state_d = S_NOTE;
        end else if (start_i && dec_xfer) begin
          state_d = S_XFER;
        end
      end
      S_XFER: begin
        if (more && !dst_full_nx) begin
          state_d = S_XFER;
        end else if (more) begin
          state_d = S_NOTE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NOTE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sc_d           = sc_q;
    qc_d           = qc_q;
    qh_d           = qh_q;
    qt_d           = qt_q;
    src_d          = src_q;
    move_d         = move_q;
    bulk_d         = bulk_q;
    note_st_d      = note_st_q;
    note_src_d     = note_src_q;
    mem_o          = '0;
    s_waddr_o      = sc_q[AW-1:0];
    s_raddr_o      = sc_m1[AW-1:0];
    s_wdata_o      = value_i;
    q_waddr_o      = qt_q;
    q_raddr_o      = qh_q;
    q_wdata_o      = value_i;
    valid_o        = 1'b0;
    result_value_o = '0;
    source_o       = note_src_q;
    status_o       = note_st_q;
    last_o         = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          src_d      = dec_src;
          move_d     = dec_move;
          bulk_d     = dec_bulk;
          note_st_d  = dec_st;
          note_src_d = dec_src;
          if (op == OP_PUSH && !s_full) begin
            mem_o.s_we = 1'b1;
            sc_d       = sc_q + CW'(1);
          end
          if (op == OP_ENQ && !q_full) begin
            mem_o.q_we = 1'b1;
            qt_d       = qt_inc;
            qc_d       = qc_q + CW'(1);
          end
          if (dec_xfer && dec_src == SRC_STACK) begin
            mem_o.s_re = 1'b1;
            sc_d       = sc_m1;
          end
          if (dec_xfer && dec_src == SRC_QUEUE) begin
            mem_o.q_re = 1'b1;
            qh_d       = qh_inc;
            qc_d       = qc_q - CW'(1);
          end
        end
      end
      S_XFER: begin
        valid_o        = 1'b1;
        result_value_o = src_q ? q_rdata_i : s_rdata_i;
        source_o       = src_q;
        status_o       = ST_OK;
        last_o         = !more;
        s_wdata_o      = q_rdata_i;
        q_wdata_o      = s_rdata_i;
        if (move_q && src_q == SRC_STACK) begin
          mem_o.q_we = 1'b1;
          qt_d       = qt_inc;
          qc_d       = qc_q + CW'(1);
        end
        if (move_q && src_q == SRC_QUEUE) begin
          mem_o.s_we = 1'b1;
          sc_d       = sc_q + CW'(1);
        end
        if (more && !dst_full_nx) begin
          if (src_q == SRC_STACK) begin
            mem_o.s_re = 1'b1;
            sc_d       = sc_m1;
          end else begin
            mem_o.q_re = 1'b1;
            qh_d       = qh_inc;
            qc_d       = qc_q - CW'(1);
          end
        end else if (more) begin
          note_st_d  = ST_FULL;
          note_src_d = src_q;
        end
      end
      S_NOTE: begin
        valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sc_q    <= '0;
      qc_q    <= '0;
      qh_q    <= '0;
      qt_q    <= '0;
    end else begin
      state_q <= state_d;
      sc_q    <= sc_d;
      qc_q    <= qc_d;
      qh_q    <= qh_d;
      qt_q    <= qt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    move_q     <= move_d;
    bulk_q     <= bulk_d;
    note_st_q  <= note_st_d;
    note_src_q <= note_src_d;
  end

  // tail must sit count entries past head, modulo the depth
  logic [CW:0] ptr_sum;
  assign ptr_sum = (CW+1)'(qh_q) + (CW+1)'(qc_q);

  `SFTE_ASSERT(a_stack_bound, sc_q <= CW'(DEPTH), "stack count beyond depth")
  `SFTE_ASSERT(a_queue_bound, qc_q <= CW'(DEPTH), "queue count beyond depth")
  `SFTE_ASSERT(a_queue_ptrs, (ptr_sum == (CW+1)'(qt_q)) || (ptr_sum == (CW+1)'(qt_q) + (CW+1)'(DEPTH)), "queue pointers inconsistent")
  `SFTE_ASSERT_NEXT(a_last_idle, valid_o && last_o, !busy_o, "busy after final transfer")
  `SFTE_ASSERT_NEXT(a_full_stop, state_q == S_XFER && !last_o, valid_o, "bulk run broke off without a result")

endmodule

FILE: hdl/stack_and_fifo_transfer_engine_top.sv
// Timing: push/enqueue give no result unless refused; other ops give the first
// result in the cycle after start, then one transfer per cycle (registered RAM read).
// Throughput: push/enqueue accept 1 item per cycle while not refused; a refused one holds busy_o
// for its result, and pops, dequeues, moves and clears hold busy_o high through their last result.
// Reset: asynchronous, active low; both structures empty, busy_o low at once.
// Results cannot be stalled: each is valid for exactly one cycle on valid_o.
module stack_and_fifo_transfer_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  output logic signed [31:0] result_value_o,
  output logic               source_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import sfte_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctl_t      mem;
  logic [AW-1:0] s_waddr, s_raddr, q_waddr, q_raddr;
  logic [31:0]   s_wdata, s_rdata, q_wdata, q_rdata, res_val;

  sfte_ram #(.DEPTH(DEPTH), .AW(AW)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem.s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (mem.s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  sfte_ram #(.DEPTH(DEPTH), .AW(AW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (mem.q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (mem.q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  sfte_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (op_i),
    .value_i        (value_i),
    .busy_o         (busy_o),
    .mem_o          (mem),
    .s_waddr_o      (s_waddr),
    .s_raddr_o      (s_raddr),
    .s_wdata_o      (s_wdata),
    .s_rdata_i      (s_rdata),
    .q_waddr_o      (q_waddr),
    .q_raddr_o      (q_raddr),
    .q_wdata_o      (q_wdata),
    .q_rdata_i      (q_rdata),
    .valid_o        (valid_o),
    .result_value_o (res_val),
    .source_o       (source_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  assign result_value_o = signed'(res_val);

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the stack and FIFO transfer engine
`timescale 1ns / 100ps

module tb_top;
  import sfte_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_OPS = 226;
  localparam logic [3:0] FIRST_SPARE_OP = 4'd10;
  localparam logic [3:0] LAST_SPARE_OP = 4'd15;

  typedef struct packed {
    logic signed [31:0] word;
    logic               src;
    logic [1:0]         status;
    logic               last;
  } transfer_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [3:0]         op_i;
  logic signed [31:0] value_i;
  logic               valid_o;
  logic signed [31:0] result_value_o;
  logic               source_o;
  logic [1:0]         status_o;
  logic               last_o;

  stack_and_fifo_transfer_engine_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .result_value_o(result_value_o),
    .source_o      (source_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of both structures
  logic signed [31:0] stack_words [DEPTH];
  logic signed [31:0] queue_words [DEPTH];
  int unsigned        stack_fill = 0;
  int unsigned        queue_rd = 0;
  int unsigned        queue_wr = 0;
  int unsigned        queue_fill = 0;

  transfer_result_t   expected_transfers [$];
  int unsigned        mismatch_count = 0;
  int unsigned        stall_cycles = 0;
  bit                 gaps_on = 1'b1;

  function automatic void post_result(logic signed [31:0] word, logic src, logic [1:0] status);
    transfer_result_t r;
    r.word = word;
    r.src = src;
    r.status = status;
    r.last = 1'b0;
    expected_transfers.push_back(r);
  endfunction

  function automatic logic signed [31:0] pop_stack_word();
    stack_fill--;
    return stack_words[stack_fill];
  endfunction

  function automatic logic signed [31:0] take_queue_word();
    logic signed [31:0] w;
    w = queue_words[queue_rd];
    queue_rd = (queue_rd + 1) % DEPTH;
    queue_fill--;
    return w;
  endfunction

  function automatic void put_queue_word(logic signed [31:0] w);
    queue_words[queue_wr] = w;
    queue_wr = (queue_wr + 1) % DEPTH;
    queue_fill++;
  endfunction

  // Works out every transfer one accepted command causes
  function automatic void predict_op(logic [3:0] op, logic signed [31:0] word);
    int unsigned      first;
    logic signed [31:0] w;
    bit               done;
    transfer_result_t tail;
    first = expected_transfers.size();
    done = 1'b0;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          post_result('0, SRC_STACK, ST_FULL);
        end else begin
          stack_words[stack_fill] = word;
          stack_fill++;
        end
      end
      OP_ENQ: begin
        if (queue_fill >= DEPTH) post_result('0, SRC_QUEUE, ST_FULL);
        else put_queue_word(word);
      end
      OP_POP, OP_CLR_S: begin
        if (stack_fill == 0) begin
          post_result('0, SRC_STACK, ST_EMPTY);
        end else if (op == OP_POP) begin
          post_result(pop_stack_word(), SRC_STACK, ST_OK);
        end else begin
          while (stack_fill > 0) post_result(pop_stack_word(), SRC_STACK, ST_OK);
        end
      end
      OP_DEQ, OP_CLR_Q: begin
        if (queue_fill == 0) begin
          post_result('0, SRC_QUEUE, ST_EMPTY);
        end else if (op == OP_DEQ) begin
          post_result(take_queue_word(), SRC_QUEUE, ST_OK);
        end else begin
          while (queue_fill > 0) post_result(take_queue_word(), SRC_QUEUE, ST_OK);
        end
      end
      OP_S2Q, OP_ALL_S2Q: begin
        if (stack_fill == 0) post_result('0, SRC_STACK, ST_EMPTY);
        while (!done && stack_fill > 0) begin
          if (queue_fill >= DEPTH) begin
            post_result('0, SRC_STACK, ST_FULL);
            done = 1'b1;
          end else begin
            w = pop_stack_word();
            put_queue_word(w);
            post_result(w, SRC_STACK, ST_OK);
            done = (op == OP_S2Q);
          end
        end
      end
      OP_Q2S, OP_ALL_Q2S: begin
        if (queue_fill == 0) post_result('0, SRC_QUEUE, ST_EMPTY);
        while (!done && queue_fill > 0) begin
          if (stack_fill >= DEPTH) begin
            post_result('0, SRC_QUEUE, ST_FULL);
            done = 1'b1;
          end else begin
            w = take_queue_word();
            stack_words[stack_fill] = w;
            stack_fill++;
            post_result(w, SRC_QUEUE, ST_OK);
            done = (op == OP_Q2S);
          end
        end
      end
      default: ;
    endcase
    if (expected_transfers.size() > first) begin
      tail = expected_transfers.pop_back();
      tail.last = 1'b1;
      expected_transfers.push_back(tail);
    end
  endfunction

  function automatic void report_mismatch(string what, transfer_result_t want,
                                          transfer_result_t got);
    if (mismatch_count < 10)
      $display("%s: exp value=%0d src=%0b status=%0d last=%0b, got value=%0d src=%0b status=%0d last=%0b",
               what, want.word, want.src, want.status, want.last,
               got.word, got.src, got.status, got.last);
    mismatch_count++;
  endfunction

  // Checks every transfer out and updates the shadow state on every command in
  always @(posedge clk_i) begin : check_results
    transfer_result_t want;
    transfer_result_t got;
    logic             moved;
    if (rst_ni) begin
      moved = valid_o | (start_i & ~busy_o);
      if (valid_o) begin
        got.word = result_value_o;
        got.src = source_o;
        got.status = status_o;
        got.last = last_o;
        if (expected_transfers.size() == 0) begin
          report_mismatch("unexpected transfer", '0, got);
        end else begin
          want = expected_transfers.pop_front();
          if (got.word !== want.word || got.src !== want.src ||
              got.status !== want.status || got.last !== want.last)
            report_mismatch("wrong transfer", want, got);
        end
      end
      if (start_i && !busy_o) predict_op(op_i, value_i);
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_op(logic [3:0] op, logic signed [31:0] word);
    if (gaps_on && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    op_i    <= op;
    value_i <= word;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic await_drain();
    start_i <= 1'b0;
    while (expected_transfers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly random words, with the extremes mixed in
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_structures();
    send_op(OP_POP, pick_word());
    send_op(OP_CLR_S, pick_word());
    send_op(OP_DEQ, pick_word());
    send_op(OP_CLR_Q, pick_word());
    send_op(OP_S2Q, pick_word());
    send_op(OP_Q2S, pick_word());
    send_op(OP_ALL_S2Q, pick_word());
    send_op(OP_ALL_Q2S, pick_word());
    send_op(FIRST_SPARE_OP, pick_word());
    send_op(LAST_SPARE_OP, pick_word());
  endtask

  task automatic test_basic_ops();
    send_op(OP_PUSH, 32'sh7fff_ffff);
    send_op(OP_PUSH, 32'sh8000_0000);
    send_op(OP_ENQ, '0);
    send_op(OP_ENQ, -32'sd1);
    send_op(OP_ENQ, 32'sh5a5a_a5a5);
    send_op(OP_S2Q, '0);
    send_op(OP_Q2S, '0);
    send_op(OP_POP, '0);
    send_op(OP_DEQ, '0);
    send_op(OP_PUSH, 32'sh0000_0001);
    send_op(OP_PUSH, 32'sh7fff_fffe);
    send_op(OP_ALL_S2Q, '0);
    send_op(OP_ALL_Q2S, '0);
    send_op(OP_ENQ, 32'sh8000_0001);
    send_op(OP_CLR_Q, '0);
    send_op(OP_CLR_S, '0);
  endtask

  // Walks both structures through full, early-stop and exact-fill transfers
  task automatic test_full_boundaries();
    repeat (DEPTH + 1) send_op(OP_PUSH, pick_word());
    repeat (DEPTH + 1) send_op(OP_ENQ, pick_word());
    send_op(OP_S2Q, pick_word());
    send_op(OP_Q2S, pick_word());
    send_op(OP_ALL_S2Q, pick_word());
    send_op(OP_ALL_Q2S, pick_word());
    repeat (5) send_op(OP_DEQ, pick_word());
    send_op(OP_ALL_S2Q, pick_word());
    send_op(OP_CLR_Q, pick_word());
    // hold the next command back until the clear has fully drained
    await_drain();
    repeat (5) send_op(OP_ENQ, pick_word());
    send_op(OP_ALL_S2Q, pick_word());
    send_op(OP_ALL_Q2S, pick_word());
    repeat (3) send_op(OP_ENQ, pick_word());
    send_op(OP_ALL_Q2S, pick_word());
    send_op(OP_CLR_S, pick_word());
    send_op(OP_CLR_Q, pick_word());
  endtask

  task automatic test_random_mix();
    int unsigned sent;
    int unsigned roll;
    logic [3:0]  op;
    sent = 0;
    while (sent < RANDOM_OPS) begin
      gaps_on = !(sent >= 60 && sent < 120);
      roll = $urandom_range(99);
      if (roll < 25)      op = OP_PUSH;
      else if (roll < 45) op = OP_ENQ;
      else if (roll < 55) op = OP_POP;
      else if (roll < 65) op = OP_DEQ;
      else if (roll < 72) op = OP_S2Q;
      else if (roll < 79) op = OP_Q2S;
      else if (roll < 85) op = OP_ALL_S2Q;
      else if (roll < 91) op = OP_ALL_Q2S;
      else if (roll < 94) op = OP_CLR_S;
      else if (roll < 97) op = OP_CLR_Q;
      else                op = FIRST_SPARE_OP + 4'($urandom_range(0, 5));
      send_op(op, pick_word());
      if (op < FIRST_SPARE_OP) sent++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    op_i    = OP_PUSH;
    value_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_structures();
    test_basic_ops();
    test_full_boundaries();
    test_random_mix();
    await_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_transfers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
